### src/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int KEY_W  = 8;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int MEM_W  = KEY_W + VAL_W;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
   localparam logic [OP_W-1:0] OP_LOWER  = 3'd3;
   localparam logic [OP_W-1:0] OP_UPPER  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

   localparam logic [CNT_W-1:0] POS_END = CNT_W'(DEPTH);

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic                    changed;
      logic [CNT_W-1:0]        position;
      logic signed [KEY_W-1:0] key_out;
      logic [VAL_W-1:0]        value_out;
      logic [CNT_W-1:0]        entry_count;
   } res_type;

endpackage

### src/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Sorted map of up to 16 signed 8-bit keys with 32-bit values in one RAM.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | operation, key_in, value_in
//   rsp     | out       | rsp_valid/rsp_stall  | status, changed, position,
//           |           |                      | key_out, value_out, entry_count
//
// one request at a time: a scan of the entries through the single RAM read
// port finds the slot, insert and erase then move the entries above the
// slot at one per cycle; worst case is an insert or erase at slot 0 of a
// (nearly) full table. clear and unused codes skip the scan. reset is
// synchronous and empties the table at once. the result register frees the
// sequencer while a beat waits on rsp_stall; a second result waits until
// that beat has gone.
// ----------------------------------------------------------------------------
module sorted_key_value_table
   import skvt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [KEY_W-1:0]  req_key_in,
   input  logic signed [VAL_W-1:0]  req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_changed,
   output logic [CNT_W-1:0]         rsp_position,
   output logic signed [KEY_W-1:0]  rsp_key_out,
   output logic signed [VAL_W-1:0]  rsp_value_out,
   output logic [CNT_W-1:0]         rsp_entry_count
);

   logic              out_free;
   logic              res_valid;
   res_type           res;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MEM_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [MEM_W-1:0]  rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_ff;

   skvt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key_in    (req_key_in),
      .req_value_in  (req_value_in),
      .out_free      (out_free),
      .res_valid     (res_valid),
      .res           (res),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   skvt_ram #(
      .WIDTH (MEM_W),
      .WORDS (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_changed     = rsp_ff.changed;
   assign rsp_position    = rsp_ff.position;
   assign rsp_key_out     = rsp_ff.key_out;
   assign rsp_value_out   = $signed(rsp_ff.value_out);
   assign rsp_entry_count = rsp_ff.entry_count;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= POS_END))
      else $error("entry count beyond table depth");

   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> (!rsp_changed && rsp_position == POS_END))
      else $error("full table result carries a change or a slot");

   a_changed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_changed) |-> (rsp_status == STAT_OK && rsp_position != POS_END))
      else $error("changed result without ok status and slot");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while sequencer busy");

endmodule

### src/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 40,
   parameter int WORDS = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// skvt_ctrl
// Request sequencer: scans the table memory for the bound slot, then shifts
// entries up or down one slot at a time for insert and erase.
// ----------------------------------------------------------------------------
module skvt_ctrl
   import skvt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_operation,
   input  logic signed [KEY_W-1:0] req_key_in,
   input  logic signed [VAL_W-1:0] req_value_in,
   input  logic                    out_free,
   output logic                    res_valid,
   output res_type                 res,
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [MEM_W-1:0]        wr_data,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic [MEM_W-1:0]        rd_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0]        val_ff, val_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    chk_ff, chk_in;
   logic [ADDR_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic                    hit_ff, hit_in;
   logic signed [KEY_W-1:0] ekey_ff, ekey_in;
   logic [VAL_W-1:0]        eval_ff, eval_in;
   logic [ADDR_W-1:0]       src_ff, src_in;
   logic [ADDR_W-1:0]       wad_ff, wad_in;
   logic                    wpend_ff, wpend_in;
   logic [CNT_W-1:0]        mv_ff, mv_in;
   logic                    up_ff, up_in;
   res_type                 res_ff, res_in;

   logic signed [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0]        rd_val;
   logic                    hit_now;
   logic                    key_eq;

   assign rd_key  = $signed(rd_data[MEM_W-1:VAL_W]);
   assign rd_val  = rd_data[VAL_W-1:0];
   assign hit_now = chk_ff && ((op_ff == OP_UPPER) ? (rd_key > key_ff) : (rd_key >= key_ff));
   assign key_eq  = hit_ff && (ekey_ff == key_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign res       = res_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      used_in   = used_ff;
      cnt_in    = cnt_ff;
      chk_in    = chk_ff;
      slot_in   = slot_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      ekey_in   = ekey_ff;
      eval_in   = eval_ff;
      src_in    = src_ff;
      wad_in    = wad_ff;
      wpend_in  = wpend_ff;
      mv_in     = mv_ff;
      up_in     = up_ff;
      res_in    = res_ff;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wad_ff;
      wr_data   = rd_data;
      rd_addr   = (state_ff == ST_SHIFT) ? src_ff : cnt_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_operation;
               key_in = req_key_in;
               val_in = req_value_in;
               cnt_in = '0;
               chk_in = 1'b0;
               res_in = '{status: STAT_OK, changed: 1'b0, position: POS_END,
                          key_out: '0, value_out: '0, entry_count: used_ff};
               case (req_operation) inside
                  OP_INSERT, OP_LOOKUP, OP_ERASE, OP_LOWER, OP_UPPER: begin
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     used_in            = '0;
                     res_in.entry_count = '0;
                     state_in           = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (hit_now) begin
               pos_in   = {1'b0, slot_ff};
               hit_in   = 1'b1;
               ekey_in  = rd_key;
               eval_in  = rd_val;
               state_in = ST_DECIDE;
            end else if (cnt_ff == used_ff) begin
               pos_in   = used_ff;
               hit_in   = 1'b0;
               state_in = ST_DECIDE;
            end else begin
               slot_in = cnt_ff[ADDR_W-1:0];
               chk_in  = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            wpend_in = 1'b0;
            res_in   = '{status: STAT_NOTFOUND, changed: 1'b0, position: POS_END,
                        key_out: '0, value_out: '0, entry_count: used_ff};
            case (op_ff)
               OP_INSERT: begin
                  if (key_eq) begin
                     res_in = '{status: STAT_OK, changed: 1'b0, position: pos_ff,
                                key_out: ekey_ff, value_out: eval_ff,
                                entry_count: used_ff};
                  end else if (used_ff == POS_END) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     res_in = '{status: STAT_OK, changed: 1'b1, position: pos_ff,
                                key_out: key_ff, value_out: val_ff,
                                entry_count: used_ff + CNT_W'(1)};
                     mv_in    = used_ff - pos_ff;
                     src_in   = ADDR_W'(used_ff - CNT_W'(1));
                     up_in    = 1'b1;
                     state_in = ST_SHIFT;
                  end
               end
               OP_LOOKUP: begin
                  if (key_eq) begin
                     res_in = '{status: STAT_OK, changed: 1'b0, position: pos_ff,
                                key_out: ekey_ff, value_out: eval_ff,
                                entry_count: used_ff};
                  end
               end
               OP_ERASE: begin
                  if (key_eq) begin
                     res_in = '{status: STAT_OK, changed: 1'b1, position: pos_ff,
                                key_out: ekey_ff, value_out: eval_ff,
                                entry_count: used_ff - CNT_W'(1)};
                     mv_in    = used_ff - pos_ff - CNT_W'(1);
                     src_in   = ADDR_W'(pos_ff + CNT_W'(1));
                     up_in    = 1'b0;
                     state_in = ST_SHIFT;
                  end
               end
               default: begin
                  // lower and upper bound
                  if (hit_ff) begin
                     res_in = '{status: STAT_OK, changed: 1'b0, position: pos_ff,
                                key_out: ekey_ff, value_out: eval_ff,
                                entry_count: used_ff};
                  end
               end
            endcase
         end

         ST_SHIFT: begin
            // each read lands one slot over on the following cycle
            wr_en = wpend_ff;
            if (mv_ff != '0) begin
               wpend_in = 1'b1;
               wad_in   = up_ff ? src_ff + ADDR_W'(1) : src_ff - ADDR_W'(1);
               src_in   = up_ff ? src_ff - ADDR_W'(1) : src_ff + ADDR_W'(1);
               mv_in    = mv_ff - CNT_W'(1);
            end else begin
               wpend_in = 1'b0;
               if (!wpend_ff) begin
                  if (op_ff == OP_INSERT) begin
                     wr_en   = 1'b1;
                     wr_addr = pos_ff[ADDR_W-1:0];
                     wr_data = {key_ff, val_ff};
                  end
                  used_in  = res_ff.entry_count;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         wpend_ff <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         wpend_ff <= wpend_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      cnt_ff  <= cnt_in;
      slot_ff <= slot_in;
      pos_ff  <= pos_in;
      hit_ff  <= hit_in;
      ekey_ff <= ekey_in;
      eval_ff <= eval_in;
      src_ff  <= src_in;
      wad_ff  <= wad_in;
      mv_ff   <= mv_in;
      up_ff   <= up_in;
      res_ff  <= res_in;
   end

endmodule
